// ===== hdl/binary_to_decimal_ascii_defines.svh =====
// Assertion macros used by the checker of binary_to_decimal_ascii.
// No dependencies.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== hdl/b2da_pkg.sv =====
// Shared constants, types and helpers for binary_to_decimal_ascii.
// No dependencies.
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int VALUE_W    = 32;
  localparam int MAG_W      = VALUE_W - 1;
  localparam int SCNT_W     = $clog2(MAG_W);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_EMIT
  } ser_state_e;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } conv_t;

  // add 3 to every BCD digit of 5 or more
  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    logic [3:0]       d;
    r = b;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      d = b[4*i +: 4];
      if (d >= 4'd5) begin
        r[4*i +: 4] = d + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/b2da_dabble.sv =====
// Bit-serial double-dabble converter: one binary bit enters the BCD register per cycle.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_dabble import b2da_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               busy_o,
  output conv_t              conv_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SCNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [BCD_W-1:0]  adj;

  assign adj = dabble_adj(bcd_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      // negative values convert as zero
      bin_d  = value_i[VALUE_W-1] ? '0 : value_i[MAG_W-1:0];
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[MAG_W-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q + SCNT_W'(1);
      if (cnt_q == SCNT_W'(MAG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o      = busy_q | done_q;
  assign conv_o.done = done_q;
  assign conv_o.bcd  = bcd_q;

endmodule

// ===== hdl/b2da_serializer.sv =====
// Digit serializer: strips leading zeros, then shifts out one ASCII digit per request.
// Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_serializer import b2da_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  conv_t             conv_i,
  output logic              idle_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] digit_char_o,
  output logic              last_o
);

  ser_state_e        state_q, state_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [BCD_W-1:0]  sh_q, sh_d;
  logic              ov_q, ov_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic [3:0]        top;
  logic              out_free;
  logic              one_left;

  assign top      = sh_q[BCD_W-1 -: 4];
  assign out_free = !ov_q || out_ready_i;
  assign one_left = (cnt_q == DCNT_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (conv_i.done) state_d = ST_SKIP;
      ST_SKIP: if (top != 4'd0 || one_left) state_d = ST_EMIT;
      ST_EMIT: if (out_free && one_left) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    ov_d   = ov_q && !out_ready_i;
    char_d = char_q;
    last_d = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (conv_i.done) begin
          sh_d  = conv_i.bcd;
          cnt_d = DCNT_W'(MAX_DIGITS);
        end
      end
      ST_SKIP: begin
        if (top == 4'd0 && !one_left) begin
          sh_d  = sh_q << 4;
          cnt_d = cnt_q - DCNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          char_d = ASCII_ZERO + CHAR_W'(top);
          last_d = one_left;
          sh_d   = sh_q << 4;
          cnt_d  = cnt_q - DCNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign out_valid_o  = ov_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

endmodule

// ===== hdl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_dabble and b2da_serializer.
`timescale 1ns / 1ps

// Converts one signed 32-bit value per request into its decimal ASCII digits,
// most significant first, no leading zeros, with last_o on the final digit.
// Zero and negative values give the single digit '0'. The double-dabble unit
// shifts one bit per cycle through all 31 magnitude bits; the serializer then
// drops each leading zero digit and sends the remaining digits one by one, and
// the next request is taken only once both are done, later if the output side
// stalls. The final digit may still wait in the output register while the next
// value is accepted.

module binary_to_decimal_ascii import b2da_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic               last_o
);

  logic  dab_busy;
  logic  ser_idle;
  logic  start;
  conv_t conv;

  assign in_ready_o = !dab_busy && ser_idle;
  assign start      = in_valid_i && in_ready_o;

  b2da_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (value_i),
    .busy_o  (dab_busy),
    .conv_o  (conv)
  );

  b2da_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .conv_i       (conv),
    .idle_o       (ser_idle),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule

// ===== hdl/b2da_checker.sv =====
// Port-level checker for binary_to_decimal_ascii, bound to the top level.
// Depends on b2da_pkg and binary_to_decimal_ascii_defines.svh.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_defines.svh"

module b2da_checker import b2da_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [CHAR_W-1:0]  digit_char_o,
  input logic               last_o
);

  logic              char_ok;
  logic              out_stall;
  logic [CHAR_W:0]   out_word;

  assign char_ok   = (digit_char_o >= CHAR_W'(48)) && (digit_char_o <= CHAR_W'(57));
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_word  = {digit_char_o, last_o};

  `B2DA_ASSERT_IMP(a_char_range, clk_i, rst_ni, out_valid_o, char_ok)
  `B2DA_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `B2DA_ASSERT_IMP(a_idle_only_last, clk_i, rst_ni, in_ready_o && out_valid_o, last_o)
  `B2DA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word))

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

// ===== test/binary_to_decimal_ascii_tb.sv =====
// Testbench for binary_to_decimal_ascii: drives signed 32-bit values and checks each
// emitted ASCII digit and its last flag against typed-in digits or a digit predictor.
// Depends on b2da_pkg and the binary_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
  import b2da_pkg::*;

  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 450;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [VALUE_W-1:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CHAR_W-1:0]  digit_char_o;
  logic               last_o;

  digit_t pending_digits[$];
  string  typed_digits_q[$];
  int     values_taken = 0;
  int     digits_seen = 0;
  int     mismatches = 0;
  int     cycles = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;

  logic [VALUE_W-1:0] dir_value [NUM_DIRECTED] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'd1000000000, 32'd999999999, 32'hAAAA_AAAA,
    32'd42, 32'd100, 32'd12345, 32'd99999, 32'h5555_5555, 32'd1234567890,
    32'd2000000000, 32'd101, 32'd7, 32'd65536
  };
  // empty string: expectation comes from the predictor
  string dir_digits [NUM_DIRECTED] = '{
    "0", "1", "9", "10", "0", "0", "2147483647", "1000000000", "999999999", "0",
    "", "", "", "", "", "", "", "", "", ""
  };

  binary_to_decimal_ascii uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .digit_char_o(digit_char_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (mismatches < 30) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic push_digit(input logic [CHAR_W-1:0] ch, input logic last);
    digit_t d;
    d.ch   = ch;
    d.last = last;
    pending_digits.push_back(d);
  endtask

  // decimal digits of a positive value, most significant first; zero or negative gives '0'
  task automatic predict_digits(input logic [VALUE_W-1:0] v);
    logic [3:0]         digs [MAX_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 n;
    n    = 0;
    rest = v;
    if (v == '0 || v[VALUE_W-1]) begin
      digs[0] = 4'd0;
      n = 1;
    end else begin
      while (rest != '0) begin
        if (n < MAX_DIGITS) begin
          digs[n] = 4'(rest % 10);
          n++;
        end
        rest = rest / 10;
      end
    end
    for (int i = n - 1; i >= 0; i--) begin
      push_digit(ASCII_ZERO + CHAR_W'(digs[i]), i == 0);
    end
  endtask

  // request and result monitor
  always @(posedge clk_i) begin
    string  s;
    digit_t exp_d;
    if (rst_ni && in_valid_i && in_ready_o) begin
      s = typed_digits_q.pop_front();
      if (s.len() != 0) begin
        for (int i = 0; i < s.len(); i++) begin
          push_digit(CHAR_W'(s[i]), i == s.len() - 1);
        end
      end else begin
        predict_digits(value_i);
      end
      values_taken <= values_taken + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      digits_seen <= digits_seen + 1;
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit char=%0d last=%0b",
                                  digit_char_o, last_o));
      end else begin
        exp_d = pending_digits.pop_front();
        if (digit_char_o !== exp_d.ch) begin
          report_mismatch($sformatf("digit_char got %0d expected %0d",
                                    digit_char_o, exp_d.ch));
        end
        if (last_o !== exp_d.last) begin
          report_mismatch($sformatf("last got %0b expected %0b (char %0d)",
                                    last_o, exp_d.last, exp_d.ch));
        end
      end
    end
  end

  // result side: random stalls, one long hold-off, a quiet stretch with no stalls
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && values_taken >= 120) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (values_taken >= 200 && values_taken < 330) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("binary_to_decimal_ascii test failed");
      $finish;
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v, input string digits, input int idx);
    if (!(idx >= 200 && idx < 330) && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk_i);
    end
    typed_digits_q.push_back(digits);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    longint unsigned    pow10 [11];
    longint unsigned    lo;
    longint unsigned    hi;
    logic [VALUE_W-1:0] v;
    int                 k;
    int                 r;
    pow10[0] = 1;
    for (int i = 1; i <= 10; i++) begin
      pow10[i] = pow10[i-1] * 10;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_value(dir_value[i], dir_digits[i], i);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        // uniform over digit counts
        k  = $urandom_range(1, 10);
        lo = (k == 1) ? 0 : pow10[k-1];
        hi = (k == 10) ? 64'd2147483647 : pow10[k] - 1;
        v  = $urandom_range(32'(hi), 32'(lo));
      end else if (r < 65) begin
        v = $urandom;
      end else if (r < 75) begin
        v = $urandom | 32'h8000_0000;
      end else if (r < 85) begin
        v = $urandom_range(120);
      end else begin
        // around a power of ten
        k = $urandom_range(1, 9);
        v = 32'(pow10[k]) + $urandom_range(2) - 1;
      end
      send_value(v, "", NUM_DIRECTED + i);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Converted %0d values into %0d checked digits, incl. a %0d-cycle output hold-off;",
             values_taken, digits_seen, HOLD_CYCLES);
    $display("zero, negative, 10-digit and power-of-ten values covered, %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("binary_to_decimal_ascii test passed");
    end else begin
      $display("binary_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule

// ===== binary_to_decimal_ascii.f =====
+incdir+hdl
hdl/b2da_pkg.sv
hdl/b2da_dabble.sv
hdl/b2da_serializer.sv
hdl/binary_to_decimal_ascii.sv
hdl/b2da_checker.sv
test/binary_to_decimal_ascii_tb.sv
